[src/assert_macros.svh]
// Assertion macros shared by the matcher RTL.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define RLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define RLM_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

[src/rlm_pkg.sv]
// Types, codes and constants of the reflector landmark matcher.
// No dependencies; imported by every module of the block.
package rlm_pkg;

    localparam int MAX_LANDMARKS_DEF = 256;
    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int CORDIC_STEPS      = 14;
    localparam int STEP_W            = 4;
    localparam int ROT_XW            = 28;
    localparam int ROT_W             = 18;
    localparam int Q_DEPTH           = 4;
    localparam int Q_AW              = 2;
    localparam int IN_DATA_W         = 168;
    localparam int OUT_DATA_W        = 80;
    localparam logic [15:0] ROT_SCALE = 16'd39797;

    localparam logic [2:0] FN_LOAD  = 3'd0;
    localparam logic [2:0] FN_SCAN  = 3'd1;
    localparam logic [2:0] FN_BEAM  = 3'd2;
    localparam logic [2:0] FN_READ  = 3'd3;
    localparam logic [2:0] FN_CLEAR = 3'd4;

    localparam logic [2:0] K_NOP    = 3'd0;
    localparam logic [2:0] K_LOAD   = 3'd1;
    localparam logic [2:0] K_SCAN   = 3'd2;
    localparam logic [2:0] K_BEAM   = 3'd3;
    localparam logic [2:0] K_REJECT = 3'd4;
    localparam logic [2:0] K_READ   = 3'd5;
    localparam logic [2:0] K_CLEAR  = 3'd6;

    localparam logic [2:0] CFG_INTENSITY_MIN = 3'd0;
    localparam logic [2:0] CFG_RANGE_MIN     = 3'd1;
    localparam logic [2:0] CFG_RANGE_MAX     = 3'd2;
    localparam logic [2:0] CFG_ANGLE_START   = 3'd3;
    localparam logic [2:0] CFG_ANGLE_STEP    = 3'd4;
    localparam logic [2:0] CFG_MATCH_RADIUS  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [15:0]        intensity_min;
        logic [15:0]        range_min_mm;
        logic [15:0]        range_max_mm;
        logic signed [15:0] angle_start;
        logic [11:0]        angle_step;
        logic [15:0]        match_radius_mm;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         kind;
        logic [11:0]        beam_index;
        logic [15:0]        range_mm;
        logic signed [23:0] landmark_x;
        logic signed [23:0] landmark_y;
        logic [7:0]         entry_index;
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic signed [15:0] pose_heading;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic               beam_accepted;
        logic               attached;
        logic [8:0]         match_count;
        logic signed [23:0] map_x;
        logic signed [23:0] map_y;
        logic               entry_detected;
        logic [15:0]        obs_count;
    } t_res;

    function automatic logic signed [16:0] atan_of(input logic [STEP_W-1:0] i);
        logic signed [16:0] v;
        case (i)
            4'd0:    v = 17'sd8192;
            4'd1:    v = 17'sd4836;
            4'd2:    v = 17'sd2555;
            4'd3:    v = 17'sd1297;
            4'd4:    v = 17'sd651;
            4'd5:    v = 17'sd326;
            4'd6:    v = 17'sd163;
            4'd7:    v = 17'sd81;
            4'd8:    v = 17'sd41;
            4'd9:    v = 17'sd20;
            4'd10:   v = 17'sd10;
            4'd11:   v = 17'sd5;
            4'd12:   v = 17'sd3;
            4'd13:   v = 17'sd1;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

endpackage

[src/rlm_front.sv]
// Front end: configuration registers, input unpacking, command classification
// and the command queue. Depends on rlm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rlm_front import rlm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_vld,
    output logic                 o_in_rdy,
    input  logic [IN_DATA_W-1:0] i_in_data,
    input  logic [2:0]           i_in_func,
    output t_cfg                 o_cfg,
    output t_cmd                 o_cmd,
    output logic                 o_cmd_vld,
    input  logic                 i_pop
);

    t_cfg             r_cfg;
    t_cmd             r_q [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr;
    logic [Q_AW-1:0]  r_rd;
    logic [Q_AW:0]    r_level;
    t_cmd             n_cmd;
    logic [15:0]      in_intensity;
    logic             push;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.intensity_min   <= 16'd800;
            r_cfg.range_min_mm    <= 16'd1500;
            r_cfg.range_max_mm    <= 16'd12000;
            r_cfg.angle_start     <= -16'sd32768;
            r_cfg.angle_step      <= 12'd46;
            r_cfg.match_radius_mm <= 16'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INTENSITY_MIN: r_cfg.intensity_min   <= i_cfg_data;
                CFG_RANGE_MIN:     r_cfg.range_min_mm    <= i_cfg_data;
                CFG_RANGE_MAX:     r_cfg.range_max_mm    <= i_cfg_data;
                CFG_ANGLE_START:   r_cfg.angle_start     <= $signed(i_cfg_data);
                CFG_ANGLE_STEP:    r_cfg.angle_step      <= i_cfg_data[11:0];
                CFG_MATCH_RADIUS:  r_cfg.match_radius_mm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_cmd.beam_index   = i_in_data[11:0];
        n_cmd.range_mm     = i_in_data[27:12];
        in_intensity       = i_in_data[43:28];
        n_cmd.landmark_x   = $signed(i_in_data[67:44]);
        n_cmd.landmark_y   = $signed(i_in_data[91:68]);
        n_cmd.entry_index  = i_in_data[99:92];
        n_cmd.pose_x       = $signed(i_in_data[123:100]);
        n_cmd.pose_y       = $signed(i_in_data[147:124]);
        n_cmd.pose_heading = $signed(i_in_data[163:148]);
        case (i_in_func)
            FN_LOAD:  n_cmd.kind = K_LOAD;
            FN_SCAN:  n_cmd.kind = K_SCAN;
            FN_BEAM: begin
                if (in_intensity > r_cfg.intensity_min && n_cmd.range_mm > r_cfg.range_min_mm
                    && n_cmd.range_mm < r_cfg.range_max_mm) begin
                    n_cmd.kind = K_BEAM;
                end else begin
                    n_cmd.kind = K_REJECT;
                end
            end
            FN_READ:  n_cmd.kind = K_READ;
            FN_CLEAR: n_cmd.kind = K_CLEAR;
            default:  n_cmd.kind = K_NOP;
        endcase
    end

    assign o_in_rdy  = (r_level != (Q_AW+1)'(Q_DEPTH));
    assign push      = i_in_vld && o_in_rdy;
    assign o_cmd_vld = (r_level != '0);
    assign pop       = i_pop && o_cmd_vld;
    assign o_cmd     = r_q[r_rd];
    assign o_cfg     = r_cfg;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_level <= r_level + 1'b1;
            end else if (pop && !push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    `RLM_ASSERT(a_q_level, r_level <= (Q_AW+1)'(Q_DEPTH), "queue level above depth")
    `RLM_ASSERT(a_q_ptrs, (r_level == '0) || (r_level == (Q_AW+1)'(Q_DEPTH)) || (r_wr != r_rd), "queue pointers disagree with level")

endmodule

[src/rlm_cordic.sv]
// Iterative rotation unit: one CORDIC step per cycle, places a range along
// an angle. Depends on rlm_pkg.
module rlm_cordic import rlm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [15:0]             i_range,
    input  logic signed [15:0]      i_angle,
    output logic                    o_done,
    output logic signed [ROT_W-1:0] o_x,
    output logic signed [ROT_W-1:0] o_y
);

    logic                     r_busy;
    logic                     r_done;
    logic [STEP_W-1:0]        r_step;
    logic signed [ROT_XW-1:0] r_x;
    logic signed [ROT_XW-1:0] r_y;
    logic signed [16:0]       r_z;
    logic [31:0]              x_prod;
    logic signed [ROT_XW-1:0] x_init;
    logic signed [16:0]       z_in;
    logic signed [16:0]       z_init;
    logic                     flip;
    logic signed [ROT_XW-1:0] sh_x;
    logic signed [ROT_XW-1:0] sh_y;
    logic signed [16:0]       step_ang;
    logic signed [ROT_XW-1:0] rnd_x;
    logic signed [ROT_XW-1:0] rnd_y;

    always_comb begin
        x_prod = i_range * ROT_SCALE;
        x_init = $signed({4'b0, x_prod[31:8]});
        z_in   = {i_angle[15], i_angle};
        flip   = 1'b0;
        z_init = z_in;
        if (i_angle > 16'sd16384) begin
            flip   = 1'b1;
            z_init = z_in - 17'sd32768;
        end else if (i_angle < -16'sd16384) begin
            flip   = 1'b1;
            z_init = z_in + 17'sd32768;
        end
        sh_x     = r_x >>> r_step;
        sh_y     = r_y >>> r_step;
        step_ang = atan_of(r_step);
        rnd_x    = r_x + ROT_XW'(128);
        rnd_y    = r_y + ROT_XW'(128);
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= flip ? -x_init : x_init;
            r_y <= '0;
            r_z <= z_init;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - sh_y;
                r_y <= r_y + sh_x;
                r_z <= r_z - step_ang;
            end else begin
                r_x <= r_x + sh_y;
                r_y <= r_y - sh_x;
                r_z <= r_z + step_ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = rnd_x[8+ROT_W-1:8];
    assign o_y    = rnd_y[8+ROT_W-1:8];

endmodule

[src/rlm_back.sv]
// Back end: command sequencer, landmark table memories, match pipeline and
// result register. Depends on rlm_pkg, rlm_cordic and assert_macros.svh.
`include "assert_macros.svh"
module rlm_back import rlm_pkg::*; #(
    parameter int MAX_LANDMARKS = MAX_LANDMARKS_DEF,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  t_cmd i_cmd,
    input  logic i_cmd_vld,
    output logic o_pop,
    output t_res o_res,
    output logic o_res_vld,
    input  logic i_res_rdy
);

    localparam int AW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int CW = $clog2(MAX_LANDMARKS + 1);
    localparam int EW = (CW > 8) ? CW : 8;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_ROTGO = 4'd2;
    localparam logic [3:0] S_ROT   = 4'd3;
    localparam logic [3:0] S_PLACE = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_SWEEP = 4'd6;
    localparam logic [3:0] S_READ  = 4'd7;
    localparam logic [3:0] S_READ2 = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic signed [23:0]     m_x   [MAX_LANDMARKS];
    logic signed [23:0]     m_y   [MAX_LANDMARKS];
    logic                   m_det [MAX_LANDMARKS];
    logic [COUNT_WIDTH-1:0] m_cnt [MAX_LANDMARKS];

    logic [3:0]             r_state;
    logic [3:0]             n_state;
    logic [CW-1:0]          r_count;
    logic signed [23:0]     r_org_x;
    logic signed [23:0]     r_org_y;
    logic signed [15:0]     r_head;
    logic                   r_ovld;
    t_res                   r_out;
    t_cmd                   r_cmd;
    t_res                   r_res;
    logic [15:0]            r_angle;
    logic signed [23:0]     r_hx;
    logic signed [23:0]     r_hy;
    logic [CW-1:0]          r_wptr;
    logic [31:0]            r_r2;

    logic signed [23:0]     r_mx_q;
    logic signed [23:0]     r_my_q;
    logic                   r_det_q;
    logic [COUNT_WIDTH-1:0] r_cnt_q;
    logic                   r_va;
    logic                   r_vb;
    logic                   r_vc;
    logic [CW-1:0]          r_ia;
    logic [CW-1:0]          r_ib;
    logic [CW-1:0]          r_ic;
    logic [COUNT_WIDTH-1:0] r_cb;
    logic [COUNT_WIDTH-1:0] r_cc;
    logic signed [24:0]     r_dx;
    logic signed [24:0]     r_dy;
    logic [48:0]            r_sx;
    logic [48:0]            r_sy;

    logic                   rot_go;
    logic                   rot_done;
    logic signed [ROT_W-1:0] rot_x;
    logic signed [ROT_W-1:0] rot_y;
    logic [23:0]            a_prod;
    logic signed [25:0]     sum_x;
    logic signed [25:0]     sum_y;
    logic signed [23:0]     sat_x;
    logic signed [23:0]     sat_y;
    logic                   issue;
    logic                   walk_end;
    logic                   hit;
    logic signed [49:0]     sq_x;
    logic signed [49:0]     sq_y;
    logic [EW-1:0]          e_ext;
    logic                   e_bad;
    logic [COUNT_WIDTH+15:0] cnt_ext;
    t_res                   res_init;

    logic                   we_xy;
    logic [AW-1:0]          wa_xy;
    logic signed [23:0]     wd_x;
    logic signed [23:0]     wd_y;
    logic                   we_det;
    logic [AW-1:0]          wa_det;
    logic                   wd_det;
    logic                   we_cnt;
    logic [AW-1:0]          wa_cnt;
    logic [COUNT_WIDTH-1:0] wd_cnt;
    logic                   re;
    logic [AW-1:0]          ra;

    rlm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_go),
        .i_range (r_cmd.range_mm),
        .i_angle ($signed(r_angle)),
        .o_done  (rot_done),
        .o_x     (rot_x),
        .o_y     (rot_y)
    );

    always_comb begin
        a_prod  = r_cmd.beam_index * i_cfg.angle_step;
        sum_x   = {{(26-ROT_W){rot_x[ROT_W-1]}}, rot_x} + {{2{r_org_x[23]}}, r_org_x};
        sum_y   = {{(26-ROT_W){rot_y[ROT_W-1]}}, rot_y} + {{2{r_org_y[23]}}, r_org_y};
        if (sum_x[25:23] == 3'b000 || sum_x[25:23] == 3'b111) begin
            sat_x = sum_x[23:0];
        end else begin
            sat_x = sum_x[25] ? 24'sh800000 : 24'sh7FFFFF;
        end
        if (sum_y[25:23] == 3'b000 || sum_y[25:23] == 3'b111) begin
            sat_y = sum_y[23:0];
        end else begin
            sat_y = sum_y[25] ? 24'sh800000 : 24'sh7FFFFF;
        end
        issue    = (r_state == S_WALK) && (r_wptr < r_count);
        walk_end = (r_wptr == r_count) && !r_va && !r_vb && !r_vc;
        sq_x     = r_dx * r_dx;
        sq_y     = r_dy * r_dy;
        hit      = r_vc && (({1'b0, r_sx} + {1'b0, r_sy}) < {18'b0, r_r2});
        e_ext    = EW'(r_cmd.entry_index);
        e_bad    = e_ext >= EW'(r_count);
        cnt_ext  = {16'b0, r_cnt_q};
        res_init = '0;
        if (i_cmd.kind == K_LOAD && r_count == CW'(MAX_LANDMARKS)) begin
            res_init.status = ST_FULL;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        rot_go  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_vld) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        K_BEAM:  n_state = S_PREP;
                        K_SCAN:  n_state = S_SWEEP;
                        K_READ:  n_state = S_READ;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_PREP:  n_state = S_ROTGO;
            S_ROTGO: begin
                rot_go  = 1'b1;
                n_state = S_ROT;
            end
            S_ROT: begin
                if (rot_done) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: n_state = (r_count == '0) ? S_DONE : S_WALK;
            S_WALK: begin
                if (walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_SWEEP: begin
                if (r_wptr == r_count) begin
                    n_state = S_DONE;
                end
            end
            S_READ:  n_state = e_bad ? S_DONE : S_READ2;
            S_READ2: n_state = S_DONE;
            S_DONE: begin
                if (!r_ovld || i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        we_xy  = 1'b0;
        wa_xy  = r_count[AW-1:0];
        wd_x   = i_cmd.landmark_x;
        wd_y   = i_cmd.landmark_y;
        we_det = 1'b0;
        wa_det = r_count[AW-1:0];
        wd_det = 1'b0;
        we_cnt = 1'b0;
        wa_cnt = r_count[AW-1:0];
        wd_cnt = '0;
        re     = 1'b0;
        ra     = r_wptr[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_cmd_vld && i_cmd.kind == K_LOAD
                    && r_count != CW'(MAX_LANDMARKS)) begin
                    we_xy  = 1'b1;
                    we_det = 1'b1;
                    we_cnt = 1'b1;
                end
            end
            S_PLACE: begin
                if (r_count == '0) begin
                    we_xy  = 1'b1;
                    wd_x   = sat_x;
                    wd_y   = sat_y;
                    we_det = 1'b1;
                    we_cnt = 1'b1;
                end
            end
            S_SWEEP: begin
                we_det = (r_wptr < r_count);
                wa_det = r_wptr[AW-1:0];
            end
            S_WALK: begin
                re     = issue;
                we_det = hit;
                wa_det = r_ic[AW-1:0];
                wd_det = 1'b1;
                we_cnt = hit;
                wa_cnt = r_ic[AW-1:0];
                wd_cnt = (r_cc == '1) ? r_cc : r_cc + 1'b1;
            end
            S_READ: begin
                re = !e_bad;
                ra = e_ext[AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_xy) begin
            m_x[wa_xy] <= wd_x;
            m_y[wa_xy] <= wd_y;
        end
        if (re) begin
            r_mx_q <= m_x[ra];
            r_my_q <= m_y[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_det) begin
            m_det[wa_det] <= wd_det;
        end
        if (re) begin
            r_det_q <= m_det[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_cnt) begin
            m_cnt[wa_cnt] <= wd_cnt;
        end
        if (re) begin
            r_cnt_q <= m_cnt[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_org_x <= '0;
            r_org_y <= '0;
            r_head  <= '0;
            r_ovld  <= 1'b0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_va    <= issue;
            r_vb    <= r_va;
            r_vc    <= r_vb;
            if (o_pop && i_cmd.kind == K_LOAD && r_count != CW'(MAX_LANDMARKS)) begin
                r_count <= r_count + 1'b1;
            end
            if (o_pop && i_cmd.kind == K_CLEAR) begin
                r_count <= '0;
            end
            if (o_pop && i_cmd.kind == K_SCAN) begin
                r_org_x <= i_cmd.pose_x;
                r_org_y <= i_cmd.pose_y;
                r_head  <= i_cmd.pose_heading;
            end
            if (r_state == S_PLACE && r_count == '0) begin
                r_count <= CW'(1);
            end
            if (r_state == S_DONE && (!r_ovld || i_res_rdy)) begin
                r_ovld <= 1'b1;
            end else if (i_res_rdy) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= i_cfg.match_radius_mm * i_cfg.match_radius_mm;
        r_ia <= r_wptr;
        r_ib <= r_ia;
        r_ic <= r_ib;
        r_cb <= r_cnt_q;
        r_cc <= r_cb;
        r_dx <= $signed({r_mx_q[23], r_mx_q}) - $signed({r_hx[23], r_hx});
        r_dy <= $signed({r_my_q[23], r_my_q}) - $signed({r_hy[23], r_hy});
        r_sx <= sq_x[48:0];
        r_sy <= sq_y[48:0];
        if (o_pop) begin
            r_cmd  <= i_cmd;
            r_res  <= res_init;
            r_wptr <= '0;
        end
        case (r_state)
            S_PREP: begin
                r_angle <= i_cfg.angle_start + a_prod[15:0] + r_head;
            end
            S_PLACE: begin
                r_hx                <= sat_x;
                r_hy                <= sat_y;
                r_res.beam_accepted <= 1'b1;
                r_res.map_x         <= sat_x;
                r_res.map_y         <= sat_y;
                if (r_count == '0) begin
                    r_res.attached <= 1'b1;
                end
            end
            S_SWEEP: begin
                if (r_wptr < r_count) begin
                    r_wptr <= r_wptr + 1'b1;
                end
            end
            S_WALK: begin
                if (issue) begin
                    r_wptr <= r_wptr + 1'b1;
                end
                if (hit) begin
                    r_res.attached <= 1'b1;
                    if (r_res.match_count != 9'h1FF) begin
                        r_res.match_count <= r_res.match_count + 1'b1;
                    end
                end
            end
            S_READ: begin
                if (e_bad) begin
                    r_res.status <= ST_RANGE;
                end
            end
            S_READ2: begin
                r_res.entry_detected <= r_det_q;
                r_res.obs_count      <= cnt_ext[15:0];
            end
            S_DONE: begin
                if (!r_ovld || i_res_rdy) begin
                    r_out <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_res     = r_out;
    assign o_res_vld = r_ovld;

    `RLM_ASSERT(a_count_max, r_count <= CW'(MAX_LANDMARKS), "entry count above table size")
    `RLM_ASSERT(a_hit_in_table, r_vc |-> (r_ic < r_count), "match write beyond entry count")
    `RLM_ASSERT_NEXT(a_pop_leaves_idle, o_pop, r_state != S_IDLE, "command popped without leaving idle")
    `RLM_ASSERT(a_walk_state, (r_va || r_vb || r_vc) |-> (r_state == S_WALK), "match pipeline busy outside walk")

endmodule

[src/reflector_landmark_matcher.sv]
// Reflector landmark matcher: lidar reflector hits against a landmark table.
// Slave stream takes commands: tuser holds the function code, tdata the
// operands. The master stream returns exactly one result per command, in order.
// Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once; the user must
// make them only while the block is idle, which the block itself does not enforce.
// A command passes a queue of four commands, then back-end states up to result
// valid: load, clear, rejected beam and unknown function go straight to done;
// read passes two read states (only the first when the index is beyond the count);
// scan start sweeps every entry; an accepted beam passes prepare, rotation start,
// rotation, place and walk (no walk with an empty table). The rotation unit is
// iterative; the match pipeline walks every table entry and reads the coordinate
// memories once per cycle. Throughput is one command at a time in the back end.
// Reset loads the default thresholds, empties the table and the queue.
// When the receiver stalls, the finished result holds in the output register,
// the back end finishes the next command and waits, and the input queue keeps
// taking commands until it fills, then drops tready.
// Depends on rlm_pkg, rlm_front, rlm_cordic and rlm_back.
module reflector_landmark_matcher import rlm_pkg::*; #(
    parameter int MAX_LANDMARKS = MAX_LANDMARKS_DEF,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // beam_index, range_mm, intensity, landmark_x, landmark_y, entry_index,
    // pose_x, pose_y, pose_heading, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [2:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, beam_accepted, attached, match_count, map_x, map_y,
    // entry_detected, obs_count, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cfg cfg;
    t_cmd cmd;
    logic cmd_vld;
    logic pop;
    t_res res;

    rlm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_vld   (s_axis_tvalid),
        .o_in_rdy   (s_axis_tready),
        .i_in_data  (s_axis_tdata),
        .i_in_func  (s_axis_tuser),
        .o_cfg      (cfg),
        .o_cmd      (cmd),
        .o_cmd_vld  (cmd_vld),
        .i_pop      (pop)
    );

    rlm_back #(
        .MAX_LANDMARKS (MAX_LANDMARKS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_cmd     (cmd),
        .i_cmd_vld (cmd_vld),
        .o_pop     (pop),
        .o_res     (res),
        .o_res_vld (m_axis_tvalid),
        .i_res_rdy (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, res.obs_count, res.entry_detected, res.map_y, res.map_x,
                           res.match_count, res.attached, res.beam_accepted, res.status};

endmodule
